// ===== hdl/tcp_sender_window_congestion_defines.svh =====
// ----------------------------------------------------------------------------
// TCP sender assertion macros
// Shared assertion forms used by the sender window and congestion logic.
// ----------------------------------------------------------------------------
`ifndef TCP_SENDER_WINDOW_CONGESTION_DEFINES_SVH
`define TCP_SENDER_WINDOW_CONGESTION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSWC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tswc_pkg.sv =====
// ----------------------------------------------------------------------------
// TCP sender package
// Codes, slot table entry type and controller states.
// ----------------------------------------------------------------------------
package tswc_pkg;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_NEW   = 2'd1;
  localparam logic [1:0] ACT_RETX  = 2'd2;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_RETRY     = 2'd1;
  localparam logic [1:0] CFG_DUP_LIMIT = 2'd2;

  localparam logic [8:0]  THRESHOLD_RESET = 9'd64;
  localparam logic [15:0] RETRY_RESET     = 16'd120;
  localparam logic [3:0]  DUP_LIMIT_RESET = 4'd3;

  typedef struct packed {
    logic        used;
    logic [31:0] seq;
  } slot_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RETX,
    ST_OUT
  } ctrl_state_t;

endpackage

// ===== hdl/tswc_ram.sv =====
// ----------------------------------------------------------------------------
// TCP sender slot memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module tswc_ram
  import tswc_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  slot_entry_t       wdata,
  input  logic [AW-1:0]     raddr,
  output slot_entry_t       rdata
);

  slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tcp_sender_window_congestion.sv =====
// ----------------------------------------------------------------------------
// TCP sender with Tahoe congestion control
// Slot table in memory, window and timer state in registers.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of its slot memory and takes no
// transaction until that pass ends. A send that fits the window and an
// acknowledgement above the base walk the slot memory one entry per cycle
// through its single read port; a send stops at the first free slot. A
// retransmit passes through a state that reads its slot from memory, and
// every other operation goes straight to the output state. A result waits
// there while out_ready holds off the result before it.
`include "tcp_sender_window_congestion_defines.svh"

module tcp_sender_window_congestion
  import tswc_pkg::*;
#(
  parameter int WINDOW_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [11:0] segment_length,
  input  logic [31:0] ack_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  action,
  output logic        accepted,
  output logic [31:0] seq_number,
  output logic [7:0]  slot_index,
  output logic [8:0]  window_now,
  output logic [8:0]  in_flight_now,
  output logic        all_acked,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SW   = $clog2(WINDOW_SLOTS);
  localparam int CW   = $clog2(WINDOW_SLOTS + 1);
  localparam int CMPW = (CW > 9) ? CW : 9;

  ctrl_state_t state, state_next;

  logic [15:0]   retry_ticks;
  logic [3:0]    dup_ack_limit;

  logic [31:0]   next_seq;
  logic [31:0]   base_seq;
  logic [CW-1:0] cong_window;
  logic [8:0]    avoid_count;
  logic [8:0]    threshold;
  logic          exp_growth;
  logic [3:0]    dup_count;
  logic [CW-1:0] in_flight;
  logic          timer_running;
  logic [15:0]   timer_left;
  logic [SW-1:0] retx_slot;

  logic [1:0]    op_q;
  logic [11:0]   len_q;
  logic [SW-1:0] clr_cnt;
  logic [SW:0]   scan_rd;
  logic          pipe_vld;
  logic [SW-1:0] ev_idx;
  logic          match_found;
  logic [SW-1:0] match_idx;

  logic [1:0]    res_action;
  logic          res_accepted;
  logic [31:0]   res_seq;
  logic [SW-1:0] res_slot;

  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  slot_entry_t   mem_wdata;
  logic [SW-1:0] mem_raddr;
  slot_entry_t   mem_rdata;

  logic          send_hit;
  logic          free_hit;
  logic          scan_done;
  logic          take;
  logic [3:0]    dup_inc;
  logic [CW-1:0] cwnd_grow;
  logic [CW-1:0] half_window;
  logic [8:0]    thr_collapse;
  logic [8:0]    avoid_inc;

  tswc_ram #(
    .DEPTH(WINDOW_SLOTS),
    .AW   (SW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign take         = in_valid && in_ready;
  assign dup_inc      = dup_count + 4'd1;
  assign cwnd_grow    = (cong_window < CW'(WINDOW_SLOTS)) ? cong_window + CW'(1) : cong_window;
  assign half_window  = cong_window >> 1;
  assign thr_collapse = (half_window > CW'(2)) ? 9'(half_window) : 9'd2;
  assign avoid_inc    = avoid_count + 9'd1;
  assign scan_done    = !pipe_vld && (scan_rd == (SW+1)'(WINDOW_SLOTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = ev_idx;
    mem_wdata  = '0;
    mem_raddr  = retx_slot;
    send_hit   = 1'b0;
    free_hit   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        if (clr_cnt == SW'(WINDOW_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          priority case (operation)
            OP_SEND: begin
              if (segment_length != 12'd0 && in_flight < cong_window) begin
                state_next = ST_SCAN;
              end else begin
                state_next = ST_OUT;
              end
            end
            OP_ACK: begin
              if (ack_number > base_seq) begin
                state_next = ST_SCAN;
              end else if (dup_inc == dup_ack_limit) begin
                state_next = ST_RETX;
              end else begin
                state_next = ST_OUT;
              end
            end
            OP_TICK: begin
              if (timer_running && timer_left <= 16'd1) begin
                state_next = ST_RETX;
              end else begin
                state_next = ST_OUT;
              end
            end
            default: state_next = ST_OUT;
          endcase
        end
      end
      ST_SCAN: begin
        mem_raddr = scan_rd[SW-1:0];
        if (pipe_vld && op_q == OP_SEND && !mem_rdata.used) begin
          send_hit       = 1'b1;
          mem_we         = 1'b1;
          mem_wdata.used = 1'b1;
          mem_wdata.seq  = next_seq;
          state_next     = ST_OUT;
        end else if (pipe_vld && op_q == OP_ACK && mem_rdata.used &&
                     mem_rdata.seq < base_seq) begin
          free_hit       = 1'b1;
          mem_we         = 1'b1;
          mem_wdata.used = 1'b0;
          mem_wdata.seq  = mem_rdata.seq;
        end else if (scan_done) begin
          state_next = ST_OUT;
        end
      end
      ST_RETX: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_ticks       <= RETRY_RESET;
      dup_ack_limit     <= DUP_LIMIT_RESET;
      threshold         <= THRESHOLD_RESET;
      next_seq          <= '0;
      base_seq          <= '0;
      cong_window       <= CW'(1);
      avoid_count       <= '0;
      exp_growth        <= 1'b1;
      dup_count         <= '0;
      in_flight         <= '0;
      timer_running     <= 1'b0;
      timer_left        <= '0;
      retx_slot         <= '0;
      clr_cnt           <= '0;
      scan_rd           <= '0;
      pipe_vld          <= 1'b0;
      match_found       <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        priority case (cfg_index)
          CFG_THRESHOLD: begin
            threshold <= cfg_data[8:0];
          end
          CFG_RETRY:     retry_ticks   <= cfg_data;
          CFG_DUP_LIMIT: dup_ack_limit <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + SW'(1);
        end
        ST_IDLE: begin
          if (take) begin
            op_q         <= operation;
            len_q        <= segment_length;
            scan_rd      <= '0;
            pipe_vld     <= 1'b0;
            match_found  <= 1'b0;
            res_action   <= ACT_NONE;
            res_accepted <= 1'b0;
            res_seq      <= '0;
            res_slot     <= '0;
            if (operation == OP_ACK) begin
              if (ack_number > base_seq) begin
                base_seq  <= ack_number;
                dup_count <= '0;
              end else if (dup_inc == dup_ack_limit) begin
                threshold     <= thr_collapse;
                cong_window   <= CW'(1);
                avoid_count   <= '0;
                exp_growth    <= 1'b1;
                dup_count     <= '0;
                timer_left    <= retry_ticks;
              end else begin
                dup_count <= dup_inc;
              end
            end else if (operation == OP_TICK && timer_running) begin
              if (timer_left <= 16'd1) begin
                threshold     <= thr_collapse;
                cong_window   <= CW'(1);
                avoid_count   <= '0;
                exp_growth    <= 1'b1;
                dup_count     <= '0;
                timer_left    <= retry_ticks;
              end else begin
                timer_left <= timer_left - 16'd1;
              end
            end
          end
        end
        ST_SCAN: begin
          if (!send_hit && scan_rd < (SW+1)'(WINDOW_SLOTS)) begin
            scan_rd  <= scan_rd + (SW+1)'(1);
            pipe_vld <= 1'b1;
            ev_idx   <= scan_rd[SW-1:0];
          end else begin
            pipe_vld <= 1'b0;
          end
          if (send_hit) begin
            res_action   <= ACT_NEW;
            res_accepted <= 1'b1;
            res_seq      <= next_seq;
            res_slot     <= ev_idx;
            next_seq     <= next_seq + 32'(len_q);
            in_flight    <= in_flight + CW'(1);
            if (!timer_running) begin
              timer_running <= 1'b1;
              timer_left    <= retry_ticks;
              retx_slot     <= ev_idx;
              base_seq      <= next_seq;
            end
          end else if (free_hit) begin
            if (in_flight != '0) begin
              in_flight <= in_flight - CW'(1);
            end
            if (exp_growth) begin
              cong_window <= cwnd_grow;
              if (CMPW'(cwnd_grow) >= CMPW'(threshold)) begin
                exp_growth <= 1'b0;
              end
            end else if (CMPW'(avoid_inc) == CMPW'(cong_window)) begin
              cong_window <= cwnd_grow;
              avoid_count <= '0;
            end else begin
              avoid_count <= avoid_inc;
            end
          end else if (pipe_vld && op_q == OP_ACK && mem_rdata.used &&
                       mem_rdata.seq == base_seq && !match_found) begin
            match_found <= 1'b1;
            match_idx   <= ev_idx;
          end else if (scan_done && op_q == OP_ACK) begin
            if (next_seq > base_seq) begin
              if (match_found) begin
                retx_slot     <= match_idx;
                timer_running <= 1'b1;
                timer_left    <= retry_ticks;
              end
            end else begin
              timer_running <= 1'b0;
            end
          end
        end
        ST_RETX: begin
          res_action <= ACT_RETX;
          res_seq    <= mem_rdata.seq;
          res_slot   <= retx_slot;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            action        <= res_action;
            accepted      <= res_accepted;
            seq_number    <= res_seq;
            slot_index    <= 8'(res_slot);
            window_now    <= 9'(cong_window);
            in_flight_now <= 9'(in_flight);
            all_acked     <= (in_flight == '0) && !timer_running;
          end
        end
        default: ;
      endcase
    end
  end

  `TSWC_ASSERT_SAME(a_window_range, 1'b1,
                    cong_window != '0 && cong_window <= CW'(WINDOW_SLOTS),
                    "congestion window out of range")
  `TSWC_ASSERT_SAME(a_flight_range, 1'b1, in_flight <= CW'(WINDOW_SLOTS),
                    "in-flight count exceeds slot count")
  `TSWC_ASSERT_SAME(a_write_in_scan, state != ST_CLEAR && mem_we,
                    state == ST_SCAN && pipe_vld,
                    "slot write outside an evaluated scan entry")
  `TSWC_ASSERT_NEXT(a_send_grows, send_hit, in_flight == $past(in_flight) + CW'(1),
                    "send did not count a segment in flight")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP sender window and congestion control testbench
// Drives sends, acknowledgements and timer ticks through the valid/ready input
// channel and checks every result against a behavioral predictor of the slot
// table, window, threshold and retransmission timer or a directed row's fixed
// values. Directed rows lead random traffic under several register settings.
// ----------------------------------------------------------------------------
module testbench;
  import tswc_pkg::*;

  localparam int SLOTS = 256;

  typedef struct packed {
    logic [1:0]  action;
    logic        taken;
    logic [31:0] seq;
    logic [7:0]  slot;
    logic [8:0]  window;
    logic [8:0]  in_flight;
    logic        all_acked;
  } seg_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] len;
    logic [31:0] ack;
    logic        typed;
    seg_result_t expected;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = OP_TICK;
  logic [11:0] segment_length = '0;
  logic [31:0] ack_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  action;
  logic        accepted;
  logic [31:0] seq_number;
  logic [7:0]  slot_index;
  logic [8:0]  window_now;
  logic [8:0]  in_flight_now;
  logic        all_acked;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_THRESHOLD;
  logic [15:0] cfg_data = '0;

  tcp_sender_window_congestion uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .segment_length(segment_length), .ack_number(ack_number),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .accepted(accepted), .seq_number(seq_number),
    .slot_index(slot_index), .window_now(window_now), .in_flight_now(in_flight_now),
    .all_acked(all_acked),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state.
  logic [31:0] slot_seq [SLOTS];
  bit          slot_used [SLOTS];
  bit          slot_written [SLOTS];
  logic [31:0] next_seq, base_seq;
  int unsigned cwnd, avoid_count, threshold, in_flight, timer_left, retx_slot;
  bit          exp_growth, timer_running;
  logic [3:0]  dup_count;
  int unsigned init_threshold, retry_ticks;
  logic [3:0]  dup_limit;

  seg_result_t expected_results [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int retransmits = 0;
  int burst_left = 0;

  function automatic logic [31:0] collapse_window();
    threshold = ((cwnd / 2) > 2 ? (cwnd / 2) : 2) & 9'h1FF;
    cwnd = 1;
    avoid_count = 0;
    exp_growth = 1'b1;
    dup_count = '0;
    timer_left = retry_ticks;
    return slot_seq[retx_slot % SLOTS];
  endfunction

  function automatic bit reads_unwritten(logic [1:0] op, logic [31:0] ack);
    return op == OP_ACK && !(ack > base_seq) && (dup_count + 4'd1) == dup_limit &&
           !slot_written[retx_slot % SLOTS];
  endfunction

  function automatic seg_result_t sender_step(logic [1:0] op, logic [11:0] len,
                                              logic [31:0] ack);
    seg_result_t r;
    int i;
    int found;
    r = '0;
    if (op == OP_SEND) begin
      if (len != 0 && in_flight < cwnd) begin
        found = -1;
        for (i = 0; i < SLOTS; i++)
          if (found < 0 && !slot_used[i]) found = i;
        if (found >= 0) begin
          slot_used[found] = 1'b1;
          slot_written[found] = 1'b1;
          slot_seq[found] = next_seq;
          r.seq = next_seq;
          r.slot = found[7:0];
          next_seq = next_seq + len;
          if (!timer_running) begin
            timer_running = 1'b1;
            timer_left = retry_ticks;
            retx_slot = found;
            base_seq = r.seq;
          end
          in_flight++;
          r.action = ACT_NEW;
          r.taken = 1'b1;
        end
      end
    end else if (op == OP_ACK) begin
      if (ack > base_seq) begin
        base_seq = ack;
        dup_count = '0;
        for (i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && slot_seq[i] < base_seq) begin
            slot_used[i] = 1'b0;
            if (in_flight > 0) in_flight--;
            if (exp_growth) begin
              if (cwnd < SLOTS) cwnd++;
              if (cwnd >= threshold) exp_growth = 1'b0;
            end else begin
              avoid_count = (avoid_count + 1) & 9'h1FF;
              if (avoid_count == cwnd) begin
                if (cwnd < SLOTS) cwnd++;
                avoid_count = 0;
              end
            end
          end
        end
        if (next_seq > base_seq) begin
          found = -1;
          for (i = 0; i < SLOTS; i++)
            if (found < 0 && slot_used[i] && slot_seq[i] == base_seq) found = i;
          if (found >= 0) begin
            retx_slot = found;
            timer_running = 1'b1;
            timer_left = retry_ticks;
          end
        end else begin
          timer_running = 1'b0;
        end
      end else begin
        dup_count = dup_count + 4'd1;
        if (dup_count == dup_limit) begin
          r.seq = collapse_window();
          r.slot = retx_slot[7:0];
          r.action = ACT_RETX;
        end
      end
    end else if (op == OP_TICK) begin
      if (timer_running) begin
        if (timer_left <= 1) begin
          r.seq = collapse_window();
          r.slot = retx_slot[7:0];
          r.action = ACT_RETX;
        end else begin
          timer_left--;
        end
      end
    end
    r.window = cwnd[8:0];
    r.in_flight = in_flight[8:0];
    r.all_acked = (in_flight == 0 && !timer_running);
    return r;
  endfunction

  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_THRESHOLD) begin
      init_threshold = value & 16'h1FF;
      threshold = init_threshold;
    end else if (idx == CFG_RETRY) begin
      retry_ticks = value;
    end else if (idx == CFG_DUP_LIMIT) begin
      dup_limit = value[3:0];
    end
  endtask

  task automatic drive_item(stim_row_t row);
    seg_result_t pred;
    int gap;
    in_valid <= 1'b1;
    operation <= row.op;
    segment_length <= row.len;
    ack_number <= row.ack;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = sender_step(row.op, row.len, row.ack);
    expected_results.push_back(row.typed ? row.expected : pred);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (expected_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("Mismatch on %s at %0t: got 0x%0h, expected 0x%0h", field, $realtime, got, want);
    errors++;
  endtask

  // Receiver: switches between always ready, light and heavy stalling.
  int ready_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 7);
      default: out_ready <= ($urandom_range(0, 9) < 2);
    endcase
  end

  always @(posedge clk) begin
    seg_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (action == ACT_RETX) retransmits++;
      if (expected_results.size() == 0) begin
        $display("Unexpected result transaction at %0t", $realtime);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (action !== want.action) report_mismatch("action", action, want.action);
        if (accepted !== want.taken) report_mismatch("accepted", accepted, want.taken);
        if (seq_number !== want.seq) report_mismatch("seq_number", seq_number, want.seq);
        if (slot_index !== want.slot) report_mismatch("slot_index", slot_index, want.slot);
        if (window_now !== want.window) report_mismatch("window_now", window_now, want.window);
        if (in_flight_now !== want.in_flight)
          report_mismatch("in_flight_now", in_flight_now, want.in_flight);
        if (all_acked !== want.all_acked) report_mismatch("all_acked", all_acked, want.all_acked);
      end
    end
  end

  function automatic stim_row_t random_row();
    stim_row_t row;
    int pick;
    int i;
    int used_list [$];
    row = '0;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      row.op = OP_SEND;
      case ($urandom_range(0, 19))
        0: row.len = '0;
        1: row.len = $urandom_range(2049, 4095);
        default: row.len = $urandom_range(1, 2048);
      endcase
      row.ack = $urandom;
    end else if (pick < 72) begin
      row.op = OP_ACK;
      row.len = $urandom;
      for (i = 0; i < SLOTS; i++)
        if (slot_used[i]) used_list.push_back(i);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: row.ack = (used_list.size() != 0) ?
            slot_seq[used_list[$urandom_range(0, used_list.size() - 1)]] +
            $urandom_range(1, 2048) : next_seq;
        4, 5: row.ack = next_seq;
        6, 7, 8: row.ack = base_seq - $urandom_range(0, 1);
        default: row.ack = $urandom;
      endcase
    end else if (pick < 96) begin
      row.op = OP_TICK;
      row.len = $urandom;
      row.ack = $urandom;
    end else begin
      row.op = 2'd3;
      row.len = $urandom;
      row.ack = $urandom;
    end
    if (reads_unwritten(row.op, row.ack)) row.op = OP_TICK;
    return row;
  endfunction

  initial begin
    stim_row_t directed [$];
    stim_row_t row;
    logic [15:0] settings [5][3];
    int p, n;
    settings = '{'{16'd64, 16'd120, 16'd3}, '{16'd2, 16'd1, 16'd1},
                 '{16'd256, 16'd65535, 16'd15}, '{16'd0, 16'd0, 16'd0},
                 '{16'd5, 16'd40, 16'd2}};
    settings[3][0] = $urandom_range(2, 256);
    settings[3][1] = $urandom_range(1, 300);
    settings[3][2] = $urandom_range(1, 15);

    init_threshold = THRESHOLD_RESET;
    retry_ticks = RETRY_RESET;
    dup_limit = DUP_LIMIT_RESET;
    for (n = 0; n < SLOTS; n++) begin
      slot_seq[n] = '0;
      slot_used[n] = 1'b0;
      slot_written[n] = 1'b0;
    end
    next_seq = '0;
    base_seq = '0;
    cwnd = 1;
    avoid_count = 0;
    threshold = init_threshold;
    exp_growth = 1'b1;
    dup_count = '0;
    in_flight = 0;
    timer_running = 1'b0;
    timer_left = 0;
    retx_slot = 0;

    directed.push_back('{OP_TICK, 12'd0, 32'd0, 1'b1, '{ACT_NONE, 0, 0, 0, 1, 0, 1}});
    directed.push_back('{OP_SEND, 12'd0, 32'd0, 1'b1, '{ACT_NONE, 0, 0, 0, 1, 0, 1}});
    directed.push_back('{2'd3, 12'hFFF, 32'hFFFFFFFF, 1'b1, '{ACT_NONE, 0, 0, 0, 1, 0, 1}});
    directed.push_back('{OP_ACK, 12'd0, 32'd0, 1'b1, '{ACT_NONE, 0, 0, 0, 1, 0, 1}});
    directed.push_back('{OP_SEND, 12'hFFF, 32'd0, 1'b1, '{ACT_NEW, 1, 0, 0, 1, 1, 0}});
    directed.push_back('{OP_SEND, 12'd1, 32'd0, 1'b1, '{ACT_NONE, 0, 0, 0, 1, 1, 0}});
    directed.push_back('{OP_ACK, 12'd0, 32'd4095, 1'b0, '0});
    directed.push_back('{OP_SEND, 12'd2048, 32'd0, 1'b0, '0});
    directed.push_back('{OP_SEND, 12'd1, 32'd0, 1'b0, '0});
    directed.push_back('{OP_ACK, 12'd0, 32'd4095, 1'b0, '0});
    directed.push_back('{OP_ACK, 12'd0, 32'd4095, 1'b0, '0});
    directed.push_back('{OP_ACK, 12'd0, 32'd4095, 1'b0, '0});
    directed.push_back('{OP_TICK, 12'd0, 32'd0, 1'b0, '0});
    directed.push_back('{OP_SEND, 12'd7, 32'd0, 1'b0, '0});
    directed.push_back('{OP_ACK, 12'd0, 32'd6144, 1'b0, '0});
    directed.push_back('{OP_ACK, 12'd0, 32'hFFFFFFFF, 1'b0, '0});
    directed.push_back('{OP_SEND, 12'd1, 32'd0, 1'b0, '0});
    directed.push_back('{OP_TICK, 12'hFFF, 32'hFFFFFFFF, 1'b0, '0});
    directed.push_back('{OP_ACK, 12'd0, 32'd0, 1'b0, '0});
    directed.push_back('{2'd3, 12'd0, 32'd0, 1'b0, '0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // Slot memory clearing pass after reset.
    repeat (SLOTS + 40) @(posedge clk);

    for (p = 0; p < 5; p++) begin
      write_register(CFG_THRESHOLD, settings[p][0]);
      write_register(CFG_RETRY, settings[p][1]);
      write_register(CFG_DUP_LIMIT, settings[p][2]);
      if (p == 0) begin
        foreach (directed[n]) drive_item(directed[n]);
      end
      for (n = 0; n < 390; n++) begin
        row = random_row();
        drive_item(row);
      end
      in_valid <= 1'b0;
      @(posedge clk);
      drain();
    end

    repeat (SLOTS + 20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    $display("Covered %0d items in 5 register settings, %0d results, %0d retransmits.",
             items_sent, results_seen, retransmits);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule
